[src/cht_pkg.sv]
// shared constants, types and hash weights for the chained hash table engine
`default_nettype none

package cht_pkg;

	// table geometry defaults
	localparam int NUM_ROWS_DEF  = 7;
	localparam int ROW_DEPTH_DEF = 8;

	// key size limits
	localparam int KEY_BYTES_MAX = 8;
	localparam int KEY_W         = 64;
	localparam int LEN_W         = 4;
	localparam int VALUE_W       = 64;

	// hash width and the split of the row reduction
	localparam int HASH_W    = 15;
	localparam int MOD_BITS  = 5;
	localparam int MOD_STEPS = HASH_W / MOD_BITS;

	// request kinds
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_ABSENT  = 2'd1;
	localparam logic [1:0] ST_PRESENT = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// one stored entry
	typedef struct packed {
		logic [HASH_W-1:0]  hash;
		logic [LEN_W-1:0]   len;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	// multiplier for a byte position, cycling 1,3,5,7,11
	function automatic logic [3:0] hash_weight(input logic [2:0] idx);
		logic [3:0] w;
		case (idx)
			3'd0:    w = 4'd1;
			3'd1:    w = 4'd3;
			3'd2:    w = 4'd5;
			3'd3:    w = 4'd7;
			3'd4:    w = 4'd11;
			default: w = 4'd1;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[src/chained_hash_table_engine.sv]
// chained hash table engine: key-value table with per-row chaining in one memory
//
// a request is taken when start is high and busy is low. busy drops in the cycle that
// shows the result, so the next request can be taken at the edge that ends that cycle.
// every request gives exactly one result, shown for one cycle with done high. the
// receiver cannot stall it, so it must take status, found and value_out in that cycle.
// a request's time from start to done grows with the key length in bytes (one byte of
// the hash per cycle) and with the number of row entries visited (one read of the
// single-port entry memory per entry). a delete that hits also passes through S_DEL_WR
// to move the row's last entry before its result is shown. the hash is reduced to a row
// five bits per cycle. no clearing pass is needed after reset: row fill counts sit in
// flip-flops and only entries below a row's count are read.
`default_nettype none

module chained_hash_table_engine
	import cht_pkg::*;
#(
	parameter int NUM_ROWS  = NUM_ROWS_DEF,
	parameter int ROW_DEPTH = ROW_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         kind,
	input  wire logic [KEY_W-1:0]   key_bytes,
	input  wire logic [LEN_W-1:0]   key_length,
	input  wire logic [VALUE_W-1:0] value_in,
	output logic                    done,
	output logic [1:0]              status,
	output logic                    found,
	output logic [VALUE_W-1:0]      value_out
);

	// derived sizes
	localparam int SLOTS = NUM_ROWS * ROW_DEPTH;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int CW    = $clog2(ROW_DEPTH + 1);

	localparam logic [RW:0]   NUM_ROWS_W  = (RW + 1)'(NUM_ROWS);
	localparam logic [CW-1:0] ROW_DEPTH_W = CW'(ROW_DEPTH);
	localparam logic [LEN_W-1:0] KEY_BYTES_W = LEN_W'(KEY_BYTES_MAX);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HASH   = 3'd1;
	localparam logic [2:0] S_MOD    = 3'd2;
	localparam logic [2:0] S_SETUP  = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_ACT    = 3'd5;
	localparam logic [2:0] S_DEL_WR = 3'd6;

	logic [2:0] state_q;

	// request held for the whole operation
	logic [1:0]         kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [LEN_W-1:0]   len_q;
	logic [VALUE_W-1:0] value_q;

	// hash accumulation
	logic [HASH_W-1:0] hash_q;
	logic [LEN_W-1:0]  byte_idx_q;
	logic [2:0]        weight_idx_q;
	logic [7:0]        cur_byte;
	logic [11:0]       term;

	// row reduction
	logic [HASH_W-1:0] mod_sh_q;
	logic [RW-1:0]     rem_q;
	logic [RW:0]       rem_next;
	logic [1:0]        mod_step_q;

	// row walk
	logic [RW-1:0] row_q;
	logic [AW-1:0] base_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] cmp_idx_q;
	logic [CW-1:0] pos_q;
	logic          pend_q;
	logic          hit_q;
	logic          match;

	// per-row fill counts
	logic [CW-1:0] row_cnt_q [NUM_ROWS];

	// entry memory, one port, registered read
	entry_t        mem [SLOTS];
	entry_t        rd_q;
	entry_t        mem_wdata;
	logic          mem_re;
	logic          mem_we;
	logic [CW-1:0] mem_off;
	logic [AW+CW-1:0] addr_sum;
	logic [AW-1:0] mem_addr;

	// result register
	logic               done_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic [VALUE_W-1:0] value_out_q;

	// request capture: saturate the length and clear the unused key bytes
	logic [LEN_W-1:0] len_sat;
	logic [KEY_W-1:0] key_masked;

	always_comb begin
		len_sat = (key_length > KEY_BYTES_W) ? KEY_BYTES_W : key_length;
		for (int b = 0; b < KEY_BYTES_MAX; b++) begin
			key_masked[b*8 +: 8] = (LEN_W'(b) < len_sat) ? key_bytes[b*8 +: 8] : 8'd0;
		end
	end

	// one hash term a cycle: byte times its position weight
	assign cur_byte = key_q[{byte_idx_q[2:0], 3'b000} +: 8];
	assign term     = cur_byte * hash_weight(weight_idx_q);

	// five remainder steps a cycle, hash bits taken msb first
	always_comb begin
		rem_next = {1'b0, rem_q};
		for (int j = 0; j < MOD_BITS; j++) begin
			rem_next = {rem_next[RW-1:0], mod_sh_q[HASH_W-1-j]};
			if (rem_next >= NUM_ROWS_W) begin
				rem_next = rem_next - NUM_ROWS_W;
			end
		end
	end

	// entry compare on the registered read data
	assign match = (rd_q.hash == hash_q) && (rd_q.len == len_q) && (rd_q.key == key_q);

	// memory access decode; reads and writes never share a cycle
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_off   = idx_q;
		mem_wdata = '{hash: hash_q, len: len_q, key: key_q, value: value_q};
		case (state_q)
			S_WALK: begin
				mem_re  = !(pend_q && match) && (idx_q < cnt_q);
				mem_off = idx_q;
			end
			S_ACT: begin
				if (kind_q == KIND_INSERT) begin
					// append at the row's fill position
					mem_we  = !hit_q && (cnt_q < ROW_DEPTH_W);
					mem_off = cnt_q;
				end else if (kind_q == KIND_DELETE) begin
					// fetch the row's last entry to fill the hole
					mem_re  = hit_q;
					mem_off = cnt_q - 1'b1;
				end
			end
			S_DEL_WR: begin
				mem_we    = 1'b1;
				mem_off   = pos_q;
				mem_wdata = rd_q;
			end
			default: begin
			end
		endcase
	end

	assign addr_sum = {{CW{1'b0}}, base_q} + {{AW{1'b0}}, mem_off};
	assign mem_addr = addr_sum[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	// request payload and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q       <= kind;
				key_q        <= key_masked;
				len_q        <= len_sat;
				value_q      <= value_in;
				hash_q       <= '0;
				byte_idx_q   <= '0;
				weight_idx_q <= '0;
			end
			S_HASH: begin
				if (byte_idx_q != len_q) begin
					hash_q     <= hash_q + HASH_W'(term);
					byte_idx_q <= byte_idx_q + 1'b1;
					weight_idx_q <= (weight_idx_q == 3'd4) ? 3'd0 : weight_idx_q + 1'b1;
				end else begin
					mod_sh_q <= hash_q;
					rem_q    <= '0;
				end
			end
			S_MOD: begin
				rem_q    <= rem_next[RW-1:0];
				mod_sh_q <= mod_sh_q << MOD_BITS;
				row_q    <= rem_next[RW-1:0];
			end
			S_SETUP: begin
				base_q <= AW'(row_q * ROW_DEPTH);
				cnt_q  <= row_cnt_q[row_q];
				idx_q  <= '0;
			end
			S_WALK: begin
				if (pend_q && match) begin
					pos_q <= cmp_idx_q;
				end else if (idx_q < cnt_q) begin
					cmp_idx_q <= idx_q;
					idx_q     <= idx_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// control: sequencer, row counts and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mod_step_q  <= '0;
			pend_q      <= 1'b0;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
			status_q    <= ST_DONE;
			found_q     <= 1'b0;
			value_out_q <= '0;
			for (int r = 0; r < NUM_ROWS; r++) begin
				row_cnt_q[r] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (byte_idx_q == len_q) begin
						mod_step_q <= '0;
						state_q    <= S_MOD;
					end
				end
				S_MOD: begin
					mod_step_q <= mod_step_q + 1'b1;
					if (mod_step_q == 2'(MOD_STEPS - 1)) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					pend_q  <= 1'b0;
					hit_q   <= 1'b0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					// one read issued and one compare done per cycle
					if (pend_q && match) begin
						hit_q   <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= S_ACT;
					end else if (idx_q < cnt_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					done_q      <= 1'b1;
					found_q     <= hit_q;
					value_out_q <= '0;
					state_q     <= S_IDLE;
					if (kind_q == KIND_INSERT) begin
						if (hit_q) begin
							status_q <= ST_PRESENT;
						end else if (cnt_q >= ROW_DEPTH_W) begin
							status_q <= ST_FULL;
						end else begin
							status_q         <= ST_DONE;
							row_cnt_q[row_q] <= cnt_q + 1'b1;
						end
					end else if (kind_q == KIND_DELETE) begin
						if (hit_q) begin
							// result waits for the move of the last entry
							done_q  <= 1'b0;
							state_q <= S_DEL_WR;
						end else begin
							status_q <= ST_ABSENT;
						end
					end else begin
						// lookup, and the unused kind code acts as one
						if (hit_q) begin
							status_q    <= ST_DONE;
							value_out_q <= rd_q.value;
						end else begin
							status_q <= ST_ABSENT;
						end
					end
				end
				S_DEL_WR: begin
					row_cnt_q[row_q] <= cnt_q - 1'b1;
					done_q           <= 1'b1;
					status_q         <= ST_DONE;
					found_q          <= 1'b1;
					value_out_q      <= '0;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign found     = found_q;
	assign value_out = value_out_q;

endmodule

`default_nettype wire

[tb/tb_chained_hash_table_engine.sv]
// self-checking testbench for the chained hash table engine, directed table then random requests
module tb_chained_hash_table_engine
	import cht_pkg::*;
();

	// table geometry as built by the default parameters
	localparam int ROWS  = NUM_ROWS_DEF;
	localparam int DEPTH = ROW_DEPTH_DEF;
	localparam int SLOTS = ROWS * DEPTH;

	// the fourth kind code is not named in the package; the block treats it as a lookup
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// byte weights by position modulo five, four bits each, position 0 in the low nibble
	localparam logic [19:0] BYTE_WEIGHTS = {4'd11, 4'd7, 4'd5, 4'd3, 4'd1};

	localparam int RANDOM_REQUESTS = 1350;
	localparam int KEY_POOL        = 80;
	localparam int IDLE_PERCENT    = 7;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int DRAIN_LIMIT     = 500;
	localparam int OWED_DEPTH      = 16;
	localparam int DIRECTED_MAX    = 32;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [VALUE_W-1:0] value;
	} op_result_t;

	typedef struct {
		logic [1:0]         kind;
		logic [KEY_W-1:0]   key;
		logic [LEN_W-1:0]   len;
		logic [VALUE_W-1:0] value;
		bit                 typed;
		op_result_t         res;
	} directed_req_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request side, known from time zero
	logic               start      = 1'b0;
	logic [1:0]         kind       = KIND_INSERT;
	logic [KEY_W-1:0]   key_bytes  = '0;
	logic [LEN_W-1:0]   key_length = '0;
	logic [VALUE_W-1:0] value_in   = '0;

	// result side
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic               found;
	logic [VALUE_W-1:0] value_out;

	// shadow copy of the table
	int unsigned        row_fill   [ROWS];
	logic [KEY_W-1:0]   slot_key   [SLOTS];
	logic [LEN_W-1:0]   slot_len   [SLOTS];
	logic [VALUE_W-1:0] slot_value [SLOTS];
	logic [HASH_W-1:0]  slot_hash  [SLOTS];

	// results still owed by the block, oldest first, in a ring
	op_result_t  owed_ring [OWED_DEPTH];
	int unsigned owed_wr = 0;
	int unsigned owed_rd = 0;
	op_result_t  head_result;

	// random keys reused so that hits, duplicates and full rows are frequent
	logic [KEY_W-1:0] pool_key [KEY_POOL];
	logic [LEN_W-1:0] pool_len [KEY_POOL];

	directed_req_t directed_rows [DIRECTED_MAX];
	int            directed_count = 0;

	bit idle_enabled = 1'b1;
	int mismatch_count = 0;
	int cycle_count = 0;
	int requests_sent = 0;
	int inserts_stored = 0;
	int full_rejects = 0;
	int key_hits = 0;

	always #5 clk = ~clk;

	chained_hash_table_engine i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.key_bytes  (key_bytes),
		.key_length (key_length),
		.value_in   (value_in),
		.done       (done),
		.status     (status),
		.found      (found),
		.value_out  (value_out)
	);

	// low len bytes set, all bytes from KEY_BYTES_MAX on
	function automatic logic [KEY_W-1:0] byte_mask(input int unsigned len);
		if (len >= KEY_BYTES_MAX)
			return '1;
		return (64'd1 << (8 * len)) - 64'd1;
	endfunction

	// results waiting to be shown by the block
	function automatic int unsigned owed_count();
		return owed_wr - owed_rd;
	endfunction

	function automatic void owe_result(input op_result_t r);
		owed_ring[owed_wr % OWED_DEPTH] = r;
		owed_wr++;
	endfunction

	// applies one request to the shadow table and returns the result it must give
	function automatic op_result_t apply_request(input logic [1:0] k,
			input logic [KEY_W-1:0] kb, input logic [LEN_W-1:0] kl,
			input logic [VALUE_W-1:0] v);
		op_result_t        res;
		int unsigned       len;
		int unsigned       acc;
		int unsigned       row;
		int unsigned       base;
		int unsigned       last;
		int                pos;
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] h;
		res = '{ST_DONE, 1'b0, '0};
		// overlong lengths saturate; bytes past the length do not take part
		len = (kl > KEY_BYTES_MAX) ? KEY_BYTES_MAX : kl;
		key = kb & byte_mask(len);
		acc = 0;
		for (int i = 0; i < len; i++)
			acc += key[8*i +: 8] * BYTE_WEIGHTS[4*(i%5) +: 4];
		h = acc[HASH_W-1:0];
		row = h % ROWS;
		base = row * DEPTH;
		pos = -1;
		for (int i = 0; i < row_fill[row]; i++) begin
			if (pos < 0 && slot_hash[base+i] == h && slot_len[base+i] == len &&
					slot_key[base+i] == key)
				pos = i;
		end
		if (pos >= 0)
			key_hits++;
		if (k == KIND_INSERT) begin
			if (pos >= 0) begin
				res.status = ST_PRESENT;
				res.found  = 1'b1;
			end else if (row_fill[row] >= DEPTH) begin
				res.status = ST_FULL;
				full_rejects++;
			end else begin
				slot_key[base+row_fill[row]]   = key;
				slot_len[base+row_fill[row]]   = LEN_W'(len);
				slot_value[base+row_fill[row]] = v;
				slot_hash[base+row_fill[row]]  = h;
				row_fill[row]++;
				inserts_stored++;
			end
		end else if (k == KIND_DELETE) begin
			if (pos < 0) begin
				res.status = ST_ABSENT;
			end else begin
				// the row's last entry fills the hole
				last = base + row_fill[row] - 1;
				slot_key[base+pos]   = slot_key[last];
				slot_len[base+pos]   = slot_len[last];
				slot_value[base+pos] = slot_value[last];
				slot_hash[base+pos]  = slot_hash[last];
				row_fill[row]--;
				res.found = 1'b1;
			end
		end else begin
			// lookup, and the spare kind code as well
			if (pos < 0) begin
				res.status = ST_ABSENT;
			end else begin
				res.found = 1'b1;
				res.value = slot_value[base+pos];
			end
		end
		return res;
	endfunction

	// presents one request until the block takes it, with random idle cycles in between;
	// idle cycles put noise on the fields with start low
	task automatic issue_request(input logic [1:0] k, input logic [KEY_W-1:0] kb,
			input logic [LEN_W-1:0] kl, input logic [VALUE_W-1:0] v,
			input bit typed, input op_result_t typed_res);
		op_result_t predicted;
		bit         taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (idle_enabled && $urandom_range(99, 0) < IDLE_PERCENT) begin
				start      <= 1'b0;
				kind       <= 2'($urandom_range(3, 0));
				key_bytes  <= {$urandom, $urandom};
				key_length <= LEN_W'($urandom_range(15, 0));
				value_in   <= {$urandom, $urandom};
			end else begin
				start      <= 1'b1;
				kind       <= k;
				key_bytes  <= kb;
				key_length <= kl;
				value_in   <= v;
				// taken at this edge when busy was low before it
				@(posedge clk);
				if (!busy)
					taken = 1'b1;
			end
		end
		requests_sent++;
		// the shadow table moves even when the result is typed in by hand
		predicted = apply_request(k, kb, kl, v);
		owe_result(typed ? typed_res : predicted);
	endtask

	task automatic add_directed(input logic [1:0] k, input logic [KEY_W-1:0] kb,
			input logic [LEN_W-1:0] kl, input logic [VALUE_W-1:0] v,
			input bit typed, input op_result_t res);
		directed_req_t d;
		d.kind  = k;
		d.key   = kb;
		d.len   = kl;
		d.value = v;
		d.typed = typed;
		d.res   = res;
		directed_rows[directed_count] = d;
		directed_count++;
	endtask

	// result checker: the block shows each result for one cycle only
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_count() == 0) begin
				$display("%0t: result with none pending: status %0d found %0b value %h",
					$time, status, found, value_out);
				mismatch_count++;
			end else begin
				head_result = owed_ring[owed_rd % OWED_DEPTH];
				owed_rd++;
				if (status !== head_result.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, head_result.status, status);
					mismatch_count++;
				end
				if (found !== head_result.found) begin
					$display("%0t: found expected %0b actual %0b",
						$time, head_result.found, found);
					mismatch_count++;
				end
				if (value_out !== head_result.value) begin
					$display("%0t: value_out expected %h actual %h",
						$time, head_result.value, value_out);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog for a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results pending", $time, owed_count());
			$display("tb_chained_hash_table_engine NOT OK");
			$finish;
		end
	end

	initial begin
		directed_req_t    d;
		logic [1:0]       k;
		logic [KEY_W-1:0] kb;
		logic [LEN_W-1:0] kl;
		int unsigned      pick;
		int unsigned      roll;
		int               drain_wait;

		for (int r = 0; r < ROWS; r++)
			row_fill[r] = 0;
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_len[i] = LEN_W'($urandom_range(KEY_BYTES_MAX, 0));
			pool_key[i] = {$urandom, $urandom} & byte_mask(32'(pool_len[i]));
		end

		// directed part: empty key, all-ones key, the spare kind, then row 0 filled
		// with one-byte keys that are multiples of seven until an insert is dropped
		add_directed(KIND_LOOKUP, '1, 4'd0, '0, 1'b1, '{ST_ABSENT, 1'b0, '0});
		add_directed(KIND_INSERT, 64'hDEAD_BEEF_0BAD_F00D, 4'd0, '1, 1'b1,
			'{ST_DONE, 1'b0, '0});
		add_directed(KIND_INSERT, '0, 4'd0, 64'd5, 1'b1, '{ST_PRESENT, 1'b1, '0});
		add_directed(KIND_LOOKUP, 64'h1234, 4'd0, '0, 1'b1, '{ST_DONE, 1'b1, '1});
		add_directed(KIND_INSERT, '1, 4'd8, '0, 1'b1, '{ST_DONE, 1'b0, '0});
		// overlong length reads as eight bytes
		add_directed(KIND_LOOKUP, '1, 4'd15, '1, 1'b1, '{ST_DONE, 1'b1, '0});
		add_directed(KIND_SPARE, '1, 4'd8, '0, 1'b1, '{ST_DONE, 1'b1, '0});
		add_directed(KIND_DELETE, '1, 4'd8, '0, 1'b1, '{ST_DONE, 1'b1, '0});
		add_directed(KIND_DELETE, '1, 4'd8, '0, 1'b1, '{ST_ABSENT, 1'b0, '0});
		// the empty key already sits in row 0, seven more entries fill it
		for (int i = 1; i <= 7; i++)
			add_directed(KIND_INSERT, 64'(7 * i), 4'd1, 64'(i), 1'b0, '0);
		add_directed(KIND_INSERT, 64'd56, 4'd1, 64'd99, 1'b1, '{ST_FULL, 1'b0, '0});
		add_directed(KIND_LOOKUP, {56'hFF_FFFF_FFFF_FFFF, 8'd49}, 4'd1, '0, 1'b0, '0);
		// deleting key 7, the row's second entry, moves the last one (key 49) into its slot
		add_directed(KIND_DELETE, 64'd7, 4'd1, '0, 1'b0, '0);
		add_directed(KIND_LOOKUP, 64'd49, 4'd1, '0, 1'b0, '0);
		add_directed(KIND_LOOKUP, 64'd7, 4'd1, '0, 1'b1, '{ST_ABSENT, 1'b0, '0});
		add_directed(KIND_INSERT, 64'd56, 4'd1, '1, 1'b0, '0);
		add_directed(KIND_LOOKUP, 64'hAB00_0000_0000_0038, 4'd1, '0, 1'b0, '0);
		add_directed(KIND_DELETE, '0, 4'd0, '0, 1'b0, '0);
		add_directed(KIND_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd4, '0, 1'b0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < directed_count; i++) begin
			d = directed_rows[i];
			issue_request(d.kind, d.key, d.len, d.value, d.typed, d.res);
		end

		// hold off until the table is quiet
		@(negedge clk);
		start <= 1'b0;
		while (owed_count() != 0)
			@(negedge clk);

		// random part: mostly pooled keys with junk above their length, some pure noise
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// a stretch with start held high back to back
			idle_enabled = (n < 500 || n >= 750);
			if (n % 300 == 150) begin
				@(negedge clk);
				start <= 1'b0;
				while (owed_count() != 0)
					@(negedge clk);
			end
			roll = $urandom_range(99, 0);
			if (roll < 10) begin
				k  = 2'($urandom_range(3, 0));
				kb = {$urandom, $urandom};
				kl = LEN_W'($urandom_range(15, 0));
			end else begin
				pick = $urandom_range(KEY_POOL - 1, 0);
				roll = $urandom_range(99, 0);
				if (roll < 45)
					k = KIND_INSERT;
				else if (roll < 70)
					k = KIND_DELETE;
				else if (roll < 95)
					k = KIND_LOOKUP;
				else
					k = KIND_SPARE;
				kb = pool_key[pick] |
					({$urandom, $urandom} & ~byte_mask(32'(pool_len[pick])));
				kl = pool_len[pick];
				if (kl == KEY_BYTES_MAX && $urandom_range(3, 0) == 0)
					kl = LEN_W'($urandom_range(15, KEY_BYTES_MAX + 1));
			end
			issue_request(k, kb, kl, {$urandom, $urandom}, 1'b0, '0);
		end

		@(negedge clk);
		start <= 1'b0;
		drain_wait = 0;
		while (owed_count() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (owed_count() != 0) begin
			$display("%0t: %0d results never arrived", $time, owed_count());
			mismatch_count++;
		end

		$display("%0d requests issued, %0d matched a stored key, %0d keys stored",
			requests_sent, key_hits, inserts_stored);
		$display("%0d inserts dropped on a full row, %0d check failures",
			full_rejects, mismatch_count);
		if (mismatch_count == 0)
			$display("tb_chained_hash_table_engine OK");
		else
			$display("tb_chained_hash_table_engine NOT OK");
		$finish;
	end

endmodule

[filelist.f]
src/cht_pkg.sv
src/chained_hash_table_engine.sv
tb/tb_chained_hash_table_engine.sv
